// File: hdl/msmsr_pkg.sv
// shared constants, types and crc function for the modbus median sensor reply block
package msmsr_pkg;

  localparam int SAMPLE_COUNT_DEF = 9;
  localparam int FRAME_LEN_DEF    = 8;

  localparam int CNT_W   = 4;   // sample counters, runs of up to 16 samples
  localparam int LUX_W   = 17;  // converted sample, signed
  localparam int SLOPE_W = 25;
  localparam int OFS_W   = 34;
  localparam int PROD_W  = 38;
  localparam int ACC_W   = 40;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] FUNC_CODE  = 8'h04;
  localparam logic [7:0] BYTE_COUNT = 8'h02;

  // register indexes of the configuration port
  localparam logic CFG_OWN_ADDR  = 1'b0;
  localparam logic CFG_REG_MATCH = 1'b1;

  // op codes carried in tuser
  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_ADC     = 1'b1;

  // piecewise-linear segments, q16.16
  localparam logic signed [SLOPE_W-1:0] SLOPE_0 = -25'sd8799519;
  localparam logic signed [SLOPE_W-1:0] SLOPE_1 = -25'sd574161;
  localparam logic signed [SLOPE_W-1:0] SLOPE_2 = -25'sd351994;
  localparam logic signed [SLOPE_W-1:0] SLOPE_3 = -25'sd25231;
  localparam logic signed [OFS_W-1:0]   OFS_0   = 34'sd3932028928;
  localparam logic signed [OFS_W-1:0]   OFS_1   = 34'sd815071232;
  localparam logic signed [OFS_W-1:0]   OFS_2   = 34'sd589830554;
  localparam logic signed [OFS_W-1:0]   OFS_3   = 34'sd89128960;

  // link between neighbouring sort cells
  typedef struct packed {
    logic signed [LUX_W-1:0] val;
    logic                    gt;   // cell is empty or holds more than the new value
  } cell_link_t;

  // one byte through the reflected crc-16
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// File: hdl/modbus_slave_median_sensor_reply_core.sv
// top level: frame receiver, sample conversion, sort chain and reply
// Usage: one input stream carries both serial request bytes and adc samples;
// in_tuser selects which (0 = byte in in_tdata[7:0], 1 = sample in in_tdata[19:8]).
// A request frame of FRAME_LEN bytes addressed to this slave, with a good crc and
// a matching register low byte, opens a run of SAMPLE_COUNT samples. Each sample
// is converted in a two-stage pipeline and inserted into a chain of sort cells,
// which keeps the run in ascending order; the median is read from the middle cell, or the mean of the middle pair.
// After the last sample a seven-byte reply leaves on the out_ stream, tlast on the
// final byte.
// Rate: serial bytes are taken one per cycle while in_tready is high. A sample is
// selected, multiplied, then added and inserted; in_tready is low from after its
// beat until it is inserted. out_tvalid rises when med_go_r starts the reply after
// the last insert; the reply then moves one byte per cycle while out_tready is high,
// and in_tready stays low until the last reply byte is taken. Items out of phase
// are taken and dropped. A stalled receiver simply holds the current reply byte.
// Reset (synchronous, rst_n low) returns to idle, crc to all ones and registers to
// slave address 4 and register match 1; the sort cells need no clearing.
module modbus_slave_median_sensor_reply_core #(
  parameter int SAMPLE_COUNT = msmsr_pkg::SAMPLE_COUNT_DEF,
  parameter int FRAME_LEN    = msmsr_pkg::FRAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] rx_byte, [19:8] adc_sample, [23:20] zero
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int CW = msmsr_pkg::CNT_W;
  localparam int LW = msmsr_pkg::LUX_W;
  localparam logic [2:0]    FRAME_END = 3'(FRAME_LEN - 1);
  localparam logic [CW-1:0] SAMP_END  = CW'(SAMPLE_COUNT - 1);
  localparam int MID_LO = (SAMPLE_COUNT - 1) / 2;
  localparam int MID_HI = SAMPLE_COUNT / 2;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_COLLECT = 4'b0010,
    PH_DISCARD = 4'b0100,
    PH_SAMPLE  = 4'b1000
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [2:0]      bc_r, bc_nxt;
  logic [15:0]     crc_r, crc_nxt, crc_fed;
  logic [7:0]      reg_lo_r, reg_lo_nxt;
  logic [CW-1:0]   sc_r, sc_nxt;
  logic [CW-1:0]   fill_r;
  logic            busy_r, busy_nxt;
  logic            last_pend_r, last_pend_nxt;
  logic            med_go_r;
  logic [7:0]      own_addr_r, reg_match_r;

  logic            in_beat, byte_beat, samp_beat, lux_start, lux_done, reply_busy;
  logic [7:0]      rx_byte;
  logic [11:0]     adc_sample;
  logic signed [LW-1:0] lux;
  logic signed [LW:0]   mid_sum, mid_adj;
  logic [15:0]     median;

  msmsr_pkg::cell_link_t links [SAMPLE_COUNT+1];

  assign rx_byte    = in_tdata[7:0];
  assign adc_sample = in_tdata[19:8];
  assign in_tready  = !busy_r && !med_go_r && !reply_busy;
  assign in_beat    = in_tvalid && in_tready;
  assign byte_beat  = in_beat && (in_tuser == msmsr_pkg::OP_RX_BYTE);
  assign samp_beat  = in_beat && (in_tuser == msmsr_pkg::OP_ADC);
  assign lux_start  = samp_beat && (phase_r == PH_SAMPLE);
  assign crc_fed    = msmsr_pkg::crc_feed(crc_r, rx_byte);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r  <= 8'd4;
      reg_match_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        msmsr_pkg::CFG_OWN_ADDR:  own_addr_r  <= cfg_wdata;
        msmsr_pkg::CFG_REG_MATCH: reg_match_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame receiver and sample run control
  always_comb begin
    phase_nxt     = phase_r;
    bc_nxt        = bc_r;
    crc_nxt       = crc_r;
    reg_lo_nxt    = reg_lo_r;
    sc_nxt        = sc_r;
    busy_nxt      = busy_r;
    last_pend_nxt = last_pend_r;
    if (lux_done) busy_nxt = 1'b0;
    if (med_go_r) last_pend_nxt = 1'b0;
    if (byte_beat) begin
      case (phase_r)
        PH_IDLE: begin
          bc_nxt = 3'd1;
          if (rx_byte == own_addr_r) begin
            crc_nxt   = msmsr_pkg::crc_feed(msmsr_pkg::CRC_INIT, rx_byte);
            phase_nxt = PH_COLLECT;
          end else begin
            phase_nxt = PH_DISCARD;
          end
        end
        PH_COLLECT: begin
          crc_nxt = crc_fed;
          if (bc_r == 3'd3) reg_lo_nxt = rx_byte;
          if (bc_r >= FRAME_END) begin
            bc_nxt = '0;
            if (crc_fed == 16'h0000 && reg_lo_nxt == reg_match_r) begin
              phase_nxt = PH_SAMPLE;
              sc_nxt    = '0;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end else begin
            bc_nxt = bc_r + 3'd1;
          end
        end
        PH_DISCARD: begin
          if (bc_r >= FRAME_END) begin
            bc_nxt    = '0;
            phase_nxt = PH_IDLE;
          end else begin
            bc_nxt = bc_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
    if (lux_start) begin
      busy_nxt = 1'b1;
      if (sc_r == SAMP_END) begin
        sc_nxt        = '0;
        phase_nxt     = PH_IDLE;
        last_pend_nxt = 1'b1;
      end else begin
        sc_nxt = sc_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bc_r        <= '0;
      crc_r       <= msmsr_pkg::CRC_INIT;
      reg_lo_r    <= '0;
      sc_r        <= '0;
      busy_r      <= 1'b0;
      last_pend_r <= 1'b0;
      med_go_r    <= 1'b0;
      fill_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      bc_r        <= bc_nxt;
      crc_r       <= crc_nxt;
      reg_lo_r    <= reg_lo_nxt;
      sc_r        <= sc_nxt;
      busy_r      <= busy_nxt;
      last_pend_r <= last_pend_nxt;
      med_go_r    <= lux_done && last_pend_r;
      // fill count of the sort chain, restarted with each run
      if (phase_r != PH_SAMPLE && phase_nxt == PH_SAMPLE) fill_r <= '0;
      else if (lux_done) fill_r <= fill_r + CW'(1);
    end
  end

  msmsr_lux u_lux (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lux_start),
    .sample (adc_sample),
    .done   (lux_done),
    .lux    (lux)
  );

  // sort chain
  assign links[0].val = '0;
  assign links[0].gt  = 1'b0;

  for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_cell
    msmsr_cell u_cell (
      .clk     (clk),
      .ins     (lux_done),
      .full    (CW'(i) < fill_r),
      .new_val (lux),
      .left    (links[i]),
      .right   (links[i+1])
    );
  end

  // median, mean of the middle pair truncated toward zero
  always_comb begin
    mid_sum = (LW+1)'(links[MID_LO+1].val) + (LW+1)'(links[MID_HI+1].val);
    mid_adj = mid_sum + (LW+1)'(mid_sum[LW] & mid_sum[0]);
    median  = 16'(mid_adj >>> 1);
  end

  msmsr_reply u_reply (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (med_go_r),
    .value      (median),
    .own_addr   (own_addr_r),
    .busy       (reply_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hdl/msmsr_lux.sv
// two-stage piecewise-linear conversion of an adc sample to lux times ten
module msmsr_lux (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [11:0]                           sample,
  output logic                                  done,
  output logic signed [msmsr_pkg::LUX_W-1:0]    lux
);

  logic                                     v1_r, v2_r;
  logic                                     zero1_r, zero2_r;
  logic        [11:0]                       r_r;
  logic signed [msmsr_pkg::SLOPE_W-1:0]     slope_r;
  logic signed [msmsr_pkg::OFS_W-1:0]       ofs1_r, ofs2_r;
  logic signed [msmsr_pkg::PROD_W-1:0]      prod_r;
  logic signed [msmsr_pkg::SLOPE_W-1:0]     slope_nxt;
  logic signed [msmsr_pkg::OFS_W-1:0]       ofs_nxt;
  logic                                     zero_nxt;
  logic signed [msmsr_pkg::ACC_W-1:0]       acc;
  logic        [msmsr_pkg::ACC_W-1:0]       mag;
  logic        [msmsr_pkg::LUX_W-1:0]       mag_q;

  // segment select
  always_comb begin
    zero_nxt  = 1'b0;
    slope_nxt = msmsr_pkg::SLOPE_3;
    ofs_nxt   = msmsr_pkg::OFS_3;
    if (sample > 12'd0 && sample < 12'd400) begin
      slope_nxt = msmsr_pkg::SLOPE_0;
      ofs_nxt   = msmsr_pkg::OFS_0;
    end else if (sample > 12'd400 && sample < 12'd1000) begin
      slope_nxt = msmsr_pkg::SLOPE_1;
      ofs_nxt   = msmsr_pkg::OFS_1;
    end else if (sample > 12'd1000 && sample < 12'd2000) begin
      slope_nxt = msmsr_pkg::SLOPE_2;
      ofs_nxt   = msmsr_pkg::OFS_2;
    end else if (sample > 12'd2000 && sample < 12'd4000) begin
      slope_nxt = msmsr_pkg::SLOPE_3;
      ofs_nxt   = msmsr_pkg::OFS_3;
    end else begin
      zero_nxt = 1'b1;
    end
  end

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  // payload pipe: select, then multiply
  always_ff @(posedge clk) begin
    r_r     <= sample;
    slope_r <= slope_nxt;
    ofs1_r  <= ofs_nxt;
    zero1_r <= zero_nxt;
    prod_r  <= msmsr_pkg::PROD_W'(slope_r * $signed({1'b0, r_r}));
    ofs2_r  <= ofs1_r;
    zero2_r <= zero1_r;
  end

  // add offset and truncate toward zero
  always_comb begin
    acc   = msmsr_pkg::ACC_W'(prod_r) + msmsr_pkg::ACC_W'(ofs2_r);
    mag   = acc[msmsr_pkg::ACC_W-1] ? msmsr_pkg::ACC_W'(-acc) : msmsr_pkg::ACC_W'(acc);
    mag_q = mag[16 +: msmsr_pkg::LUX_W];
    if (zero2_r)                       lux = '0;
    else if (acc[msmsr_pkg::ACC_W-1])  lux = -$signed(mag_q);
    else                               lux = $signed(mag_q);
  end

  assign done = v2_r;

endmodule

// File: hdl/msmsr_cell.sv
// one cell of the insertion sort chain, holding one converted sample
module msmsr_cell (
  input  logic                    clk,
  input  logic                    ins,
  input  logic                    full,
  input  logic signed [msmsr_pkg::LUX_W-1:0] new_val,
  input  msmsr_pkg::cell_link_t   left,
  output msmsr_pkg::cell_link_t   right
);

  logic signed [msmsr_pkg::LUX_W-1:0] val_r;
  logic                               gt;

  assign gt = !full || (val_r > new_val);

  // shift right when the new value goes at or before this cell
  always_ff @(posedge clk) begin
    if (ins && gt) begin
      val_r <= left.gt ? left.val : new_val;
    end
  end

  assign right.val = val_r;
  assign right.gt  = gt;

endmodule

// File: hdl/msmsr_reply.sv
// reply sequencer: sends the seven reply bytes and builds their crc on the way
module msmsr_reply (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] value,
  input  logic [7:0]  own_addr,
  output logic        busy,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  localparam logic [2:0] LAST_IDX = 3'd6;
  localparam logic [2:0] CRC_LO   = 3'd5;

  logic        active_r, active_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] value_r;
  logic [7:0]  addr_r;
  logic [7:0]  byte_q;
  logic        beat;

  // byte select
  always_comb begin
    case (idx_r)
      3'd0:    byte_q = addr_r;
      3'd1:    byte_q = msmsr_pkg::FUNC_CODE;
      3'd2:    byte_q = msmsr_pkg::BYTE_COUNT;
      3'd3:    byte_q = value_r[15:8];
      3'd4:    byte_q = value_r[7:0];
      3'd5:    byte_q = crc_r[7:0];
      default: byte_q = crc_r[15:8];
    endcase
  end

  assign beat = active_r && out_tready;

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    if (start) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
      crc_nxt    = msmsr_pkg::CRC_INIT;
    end else if (beat) begin
      if (idx_r < CRC_LO) crc_nxt = msmsr_pkg::crc_feed(crc_r, byte_q);
      if (idx_r == LAST_IDX) active_nxt = 1'b0;
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      crc_r    <= msmsr_pkg::CRC_INIT;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      crc_r    <= crc_nxt;
    end
  end

  // latch reply payload at start
  always_ff @(posedge clk) begin
    if (start) begin
      value_r <= value;
      addr_r  <= own_addr;
    end
  end

  assign busy       = active_r;
  assign out_tvalid = active_r;
  assign out_tdata  = byte_q;
  assign out_tlast  = (idx_r == LAST_IDX);

endmodule

// File: test/modbus_slave_median_sensor_reply_core_test.sv
// self-checking testbench for the modbus median light sensor reply core
module modbus_slave_median_sensor_reply_core_test;

  localparam int N_SAMP = 9;
  localparam int N_FRAME = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_COLLECT = 2'd1,
    ST_DISCARD = 2'd2,
    ST_SAMPLE  = 2'd3
  } rx_state_e;

  typedef struct {
    logic        op;
    logic [7:0]  rx_byte;
    logic [11:0] adc;
  } in_item_t;

  typedef struct {
    logic [7:0] tx_byte;
    logic       last;
  } reply_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  in_item_t    pending_items[$];
  reply_beat_t reply_expected[$];
  int          errors = 0;
  int          cycles = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          no_idle = 0;

  // predictor copy of configuration and state
  logic [7:0]        my_addr = 8'd4;
  logic [7:0]        my_match = 8'd1;
  rx_state_e         rx_state = ST_IDLE;
  logic [2:0]        frame_idx = '0;
  logic [15:0]       frame_crc = 16'hFFFF;
  logic [7:0]        reg_low = '0;
  int                lux_store[N_SAMP];
  logic [3:0]        samp_idx = '0;

  modbus_slave_median_sensor_reply_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // reflected crc-16 over one byte
  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  // piecewise-linear conversion to lux times ten, truncated toward zero
  function automatic int lux_of_sample(int r);
    longint sl, of, v;
    if (r > 0 && r < 400) begin
      sl = -8799519; of = 64'd3932028928;
    end else if (r > 400 && r < 1000) begin
      sl = -574161; of = 815071232;
    end else if (r > 1000 && r < 2000) begin
      sl = -351994; of = 589830554;
    end else if (r > 2000 && r < 4000) begin
      sl = -25231; of = 89128960;
    end else begin
      return 0;
    end
    v = sl * r + of;
    if (v >= 0) return int'(v >>> 16);
    return -int'((-v) >>> 16);
  endfunction

  function automatic int median_lux();
    int a[N_SAMP];
    int t;
    a = lux_store;
    for (int i = 0; i < N_SAMP - 1; i++)
      for (int j = 0; j < N_SAMP - 1 - i; j++)
        if (a[j] > a[j+1]) begin
          t = a[j]; a[j] = a[j+1]; a[j+1] = t;
        end
    return a[N_SAMP/2];
  endfunction

  // advance the predictor by one accepted beat, queueing any reply bytes
  task automatic predict_reply(in_item_t it);
    logic [7:0]  fr[7];
    logic [15:0] c;
    logic [31:0] u;
    if (it.op == msmsr_pkg::OP_RX_BYTE) begin
      case (rx_state)
        ST_IDLE: begin
          frame_idx = 3'd1;
          if (it.rx_byte == my_addr) begin
            frame_crc = crc16_step(16'hFFFF, it.rx_byte);
            rx_state = ST_COLLECT;
          end else begin
            rx_state = ST_DISCARD;
          end
        end
        ST_COLLECT: begin
          frame_crc = crc16_step(frame_crc, it.rx_byte);
          if (frame_idx == 3'd3) reg_low = it.rx_byte;
          if (frame_idx >= N_FRAME - 1) begin
            frame_idx = '0;
            if (frame_crc == 16'h0000 && reg_low == my_match) begin
              rx_state = ST_SAMPLE;
              samp_idx = '0;
            end else begin
              rx_state = ST_IDLE;
            end
          end else begin
            frame_idx = frame_idx + 3'd1;
          end
        end
        ST_DISCARD: begin
          if (frame_idx >= N_FRAME - 1) begin
            frame_idx = '0;
            rx_state = ST_IDLE;
          end else begin
            frame_idx = frame_idx + 3'd1;
          end
        end
        default: ;
      endcase
    end else if (rx_state == ST_SAMPLE) begin
      lux_store[samp_idx] = lux_of_sample(int'(it.adc));
      samp_idx = samp_idx + 4'd1;
      if (samp_idx >= N_SAMP) begin
        samp_idx = '0;
        rx_state = ST_IDLE;
        u = median_lux();
        fr[0] = my_addr; fr[1] = msmsr_pkg::FUNC_CODE; fr[2] = msmsr_pkg::BYTE_COUNT;
        fr[3] = u[15:8]; fr[4] = u[7:0];
        c = 16'hFFFF;
        for (int i = 0; i < 5; i++) c = crc16_step(c, fr[i]);
        fr[5] = c[7:0]; fr[6] = c[15:8];
        for (int i = 0; i < 7; i++) reply_expected.push_back('{fr[i], i == 6});
      end
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item_t it;
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= it.op;
        in_tdata <= {4'h0, it.adc, it.rx_byte};
        gap_left <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!no_idle) stall_left <= pick_gap();
    end
  end

  // monitor: predict on accepted input beats, check accepted reply beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        predict_reply('{in_tuser, in_tdata[7:0], in_tdata[19:8]});
      if (out_tvalid && out_tready) begin
        if (reply_expected.size() == 0) begin
          $display("%0t: unexpected reply beat, expected none, actual tdata %02h tlast %0b",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          reply_beat_t e;
          e = reply_expected.pop_front();
          if (out_tdata !== e.tx_byte) begin
            $display("%0t: tx_byte mismatch, expected %02h actual %02h",
                     $time, e.tx_byte, out_tdata);
            errors++;
          end
          if (out_tlast !== e.last) begin
            $display("%0t: tlast mismatch, expected %0b actual %0b", $time, e.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL modbus_slave_median_sensor_reply_core");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b);
    pending_items.push_back('{msmsr_pkg::OP_RX_BYTE, b, 12'($urandom)});
  endtask

  task automatic push_sample(logic [11:0] s);
    pending_items.push_back('{msmsr_pkg::OP_ADC, 8'($urandom), s});
  endtask

  // request frame; kind 0 good, 1 bad crc, 2 register mismatch, 3 foreign address
  task automatic push_request(int kind);
    logic [7:0]  fr[N_FRAME];
    logic [15:0] c;
    fr[0] = my_addr;
    if (kind == 3) while (fr[0] == my_addr) fr[0] = 8'($urandom);
    fr[1] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : msmsr_pkg::FUNC_CODE;
    fr[2] = 8'($urandom);
    fr[3] = my_match;
    if (kind == 2) while (fr[3] == my_match) fr[3] = 8'($urandom);
    fr[4] = 8'($urandom);
    fr[5] = 8'($urandom);
    c = 16'hFFFF;
    for (int i = 0; i < N_FRAME - 2; i++) c = crc16_step(c, fr[i]);
    if (kind == 1) c = c ^ (16'h1 << $urandom_range(0, 15));
    fr[6] = c[7:0];
    fr[7] = c[15:8];
    for (int i = 0; i < N_FRAME; i++) push_byte(fr[i]);
  endtask

  function automatic logic [11:0] rand_sample();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 12'(400 * $urandom_range(0, 1) + 1000 * $urandom_range(0, 2));
      1: return 12'($urandom_range(3995, 4095));
      2: return 12'($urandom_range(1, 40));
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic wait_quiet();
    while (pending_items.size() > 0 || in_tvalid || reply_expected.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [7:0] addr_v, logic [7:0] match_v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= msmsr_pkg::CFG_OWN_ADDR; cfg_wdata <= addr_v;
    @(posedge clk);
    cfg_addr <= msmsr_pkg::CFG_REG_MATCH; cfg_wdata <= match_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    my_addr = addr_v;
    my_match = match_v;
  endtask

  task automatic random_traffic(int n_items);
    int start;
    int p;
    start = pending_items.size();
    while (pending_items.size() - start < n_items) begin
      p = $urandom_range(0, 99);
      if (p < 65) begin
        push_request(0);
        for (int i = 0; i < N_SAMP; i++) begin
          if ($urandom_range(0, 19) == 0) push_byte(8'($urandom));
          push_sample(rand_sample());
        end
      end else if (p < 75) push_request(1);
      else if (p < 85) push_request(2);
      else if (p < 95) push_request(3);
      else push_sample(12'($urandom));
    end
  endtask

  // stimulus sequence
  initial begin
    logic [7:0] a_v, m_v;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stray sample, good request, extreme samples and a byte mid-run
    no_idle = 1;
    push_sample(12'd1234);
    push_request(0);
    push_sample(12'd0);
    push_sample(12'd400);
    push_sample(12'd1000);
    push_byte(8'hFF);
    push_sample(12'd2000);
    push_sample(12'd4000);
    push_sample(12'd4095);
    push_sample(12'd1);
    push_sample(12'd399);
    push_sample(12'd3999);
    wait_quiet();

    // random traffic with idle gaps and receiver stalls, then wait until every reply byte has drained
    no_idle = 0;
    random_traffic(60);
    wait_quiet();

    // several register settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin a_v = 8'h00; m_v = 8'h00; end
        1: begin a_v = 8'hFF; m_v = 8'hFF; end
        2: begin a_v = 8'h04; m_v = 8'h01; end
        default: begin a_v = 8'($urandom); m_v = 8'($urandom); end
      endcase
      write_cfg(a_v, m_v);
      no_idle = (ph == 2);
      random_traffic(65);
      wait_quiet();
    end

    repeat (30) @(posedge clk);
    if (errors == 0) $display("PASS modbus_slave_median_sensor_reply_core");
    else $display("FAIL modbus_slave_median_sensor_reply_core");
    $finish;
  end

endmodule

// File: sim.f
hdl/msmsr_pkg.sv
hdl/msmsr_lux.sv
hdl/msmsr_cell.sv
hdl/msmsr_reply.sv
hdl/modbus_slave_median_sensor_reply_core.sv
test/modbus_slave_median_sensor_reply_core_test.sv
